/* rtl/sopd_pkg.sv */
// Shared types and constants for the second-order pseudo-differentiator.
package sopd_pkg;

	// Register widths and the configuration port.
	localparam int BW_W       = 24;
	localparam int SH_W       = 16;
	localparam int SP_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_BANDWIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHARPNESS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

	// Register values after reset.
	localparam logic [BW_W-1:0] RST_BANDWIDTH     = 24'd256000;
	localparam logic [SH_W-1:0] RST_SHARPNESS     = 16'd4096;
	localparam logic [SP_W-1:0] RST_SAMPLE_PERIOD = 32'd429497;

	// Operation codes carried in the input tuser.
	localparam logic OP_FILTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	// Intermediate widths of the coefficient derivation.
	localparam int XQ_W     = 40;
	localparam int XSQ_W    = 80;
	localparam int T3_W     = 96;
	localparam int WW_W     = 48;
	localparam int XQ_SHIFT = 16;
	localparam int T1_SHIFT = 50;
	localparam int T2_SHIFT = 37;
	localparam int B_SHIFT  = 24;
	localparam int BT_SHIFT = 8;

	// Serial multiplier and wide accumulator widths.
	localparam int MA_W    = 80;
	localparam int MB_W    = 64;
	localparam int ACC_W   = 128;
	localparam int DIGIT_W = 8;

	// Sequencer states.
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_XQ,
		ST_XSQ,
		ST_T3,
		ST_DCHK,
		ST_DIV1,
		ST_DIV2,
		ST_DIV3,
		ST_WW,
		ST_BW,
		ST_KC,
		ST_BT,
		ST_K1,
		ST_K2,
		ST_K3,
		ST_RND,
		ST_OUT
	} state_t;

endpackage

/* rtl/sopd_mul.sv */
// Digit-serial unsigned multiplier, one 8-bit digit of the multiplier per cycle.
module sopd_mul import sopd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [MA_W-1:0]  a,
	input  logic [MB_W-1:0]  b,
	output logic             done,
	output logic [ACC_W-1:0] product
);

	logic                       busy_q;
	logic [ACC_W-1:0]           a_q;
	logic [MB_W-1:0]            b_q;
	logic [ACC_W-1:0]           p_q;
	logic [ACC_W+DIGIT_W-1:0]   partial;

	// Partial product of the shifted multiplicand and the lowest digit.
	assign partial = a_q * b_q[DIGIT_W-1:0];

	// The product is complete once no nonzero digit remains.
	assign done    = busy_q && (b_q == '0);
	assign product = p_q;

	// Busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (done) begin
			busy_q <= 1'b0;
		end
	end

	// Operand shift registers and the running sum.
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= ACC_W'(a);
			b_q <= b;
			p_q <= '0;
		end else if (busy_q && (b_q != '0)) begin
			a_q <= a_q << DIGIT_W;
			b_q <= b_q >> DIGIT_W;
			p_q <= p_q + partial[ACC_W-1:0];
		end
	end

endmodule

/* rtl/sopd_div.sv */
// Bit-serial restoring divider giving floor(num * 2^FRAC_BITS / den) for num <= den.
module sopd_div import sopd_pkg::*; #(
	parameter int FRAC_BITS = 30
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ACC_W-1:0]   num,
	input  logic [ACC_W-1:0]   den,
	output logic               done,
	output logic [FRAC_BITS:0] quotient
);

	localparam int STEPS = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic               busy_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [ACC_W-1:0]   r_q;
	logic [FRAC_BITS:0] q_q;
	logic [ACC_W-1:0]   r_shift;
	logic               ge;

	// The first step compares the numerator as given, later ones after a shift.
	assign r_shift  = (cnt_q == '0) ? r_q : (r_q << 1);
	assign ge       = (r_shift >= den);
	assign done     = busy_q && (cnt_q == CNT_W'(STEPS));
	assign quotient = q_q;

	// Step counter and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Partial remainder and quotient bits, one bit a cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= num;
			q_q <= '0;
		end else if (busy_q && !done) begin
			r_q <= ge ? (r_shift - den) : r_shift;
			q_q <= {q_q[FRAC_BITS-1:0], ge};
		end
	end

endmodule

/* rtl/second_order_pseudo_differentiator.sv */
// Top level: with current coefficients a filter request makes four passes through the shared
// digit-serial multiplier, then a rounding state, and waits in the output state until the output is free.
// The first filter request after reset or any register write first derives the coefficients
// through the multiplier and the bit-serial divider. A clear request gives no result, and
// one request is in work at a time.
// Reset loads the register defaults, zeroes all history and marks coefficients stale.
module second_order_pseudo_differentiator import sopd_pkg::*; #(
	parameter int SAMPLE_WIDTH   = 24,
	parameter int OUTPUT_WIDTH   = 48,
	parameter int COEF_FRAC_BITS = 30
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_tdata,   // sample
	input  logic                                  s_tuser,   // operation
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [((OUTPUT_WIDTH+7)/8)*8-1:0]     m_tdata,   // filtered
	output logic                                  m_tuser,   // saturated
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data
);

	localparam int F     = COEF_FRAC_BITS;
	localparam int C_W   = F + 1;
	localparam int K_W   = F + 4;
	localparam int B_W   = (F + 25 > 64) ? 64 : F + 25;
	localparam int DU_W  = SAMPLE_WIDTH + 2;
	localparam int OW    = OUTPUT_WIDTH;
	localparam int MD_W  = ((OUTPUT_WIDTH + 7) / 8) * 8;

	state_t state_q, state_d;

	logic issued_q, coef_ok_q;
	logic [BW_W-1:0] bandwidth_q;
	logic [SH_W-1:0] sharpness_q;
	logic [SP_W-1:0] period_q;

	logic signed [SAMPLE_WIDTH-1:0] hu0_q, hu1_q, hu2_q, u_q;
	logic signed [OW-1:0]           hy0_q, hy1_q, hy2_q;

	logic [XQ_W-1:0]     xq_q;
	logic [XSQ_W-1:0]    xsq_q;
	logic [T3_W-1:0]     t3_q;
	logic [ACC_W-1:0]    den_q;
	logic [C_W-1:0]      c1_q, c2_q, c3_q;
	logic [WW_W-1:0]     ww_q;
	logic [B_W-1:0]      coef_b_q;
	logic signed [K_W-1:0] k1_q, k2_q, k3_q;
	logic [ACC_W-1:0]    acc_q;

	logic          m_tvalid_q, m_sat_q;
	logic [OW-1:0] m_data_q;

	logic             mul_start, mul_done, div_start, div_done;
	logic [MA_W-1:0]  mul_a;
	logic [MB_W-1:0]  mul_b;
	logic [ACC_W-1:0] prod, div_num, t1, t2;
	logic [C_W-1:0]   quot;

	logic signed [DU_W-1:0] du;
	logic [DU_W-1:0]        du_mag;
	logic [K_W-1:0]         k1_mag, k2_mag, k3_mag;
	logic [OW-1:0]          y0_mag, y1_mag, y2_mag;
	logic signed [ACC_W-1:0] acc_sh;
	logic [ACC_W-OW:0]      hi_bits;
	logic                   fits, out_free, in_acc, cfg_acc;
	logic [OW-1:0]          y_next;

	// Shared arithmetic units.
	sopd_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (prod)
	);

	sopd_div #(.FRAC_BITS(F)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      (div_num),
		.den      (den_q),
		.done     (div_done),
		.quotient (quot)
	);

	// Denominator terms that are plain shifts of the registers.
	assign t1 = ACC_W'(sharpness_q) << T1_SHIFT;
	assign t2 = ACC_W'(xq_q) << T2_SHIFT;

	// Input difference and operand magnitudes.
	assign du     = DU_W'(hu2_q) - DU_W'(hu1_q) - DU_W'(hu0_q) + DU_W'(u_q);
	assign du_mag = du[DU_W-1] ? DU_W'(-du) : DU_W'(du);
	assign k1_mag = k1_q[K_W-1] ? K_W'(-k1_q) : K_W'(k1_q);
	assign k2_mag = k2_q[K_W-1] ? K_W'(-k2_q) : K_W'(k2_q);
	assign k3_mag = k3_q[K_W-1] ? K_W'(-k3_q) : K_W'(k3_q);
	assign y0_mag = hy0_q[OW-1] ? OW'(-hy0_q) : OW'(hy0_q);
	assign y1_mag = hy1_q[OW-1] ? OW'(-hy1_q) : OW'(hy1_q);
	assign y2_mag = hy2_q[OW-1] ? OW'(-hy2_q) : OW'(hy2_q);

	// Rounded sum scaled back to integer, then saturated.
	assign acc_sh  = $signed(acc_q) >>> F;
	assign hi_bits = acc_sh[ACC_W-1:OW-1];
	assign fits    = (&hi_bits) || !(|hi_bits);
	assign y_next  = fits ? acc_sh[OW-1:0] :
		(acc_q[ACC_W-1] ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}});

	// Handshakes.
	assign out_free  = !m_tvalid_q || m_tready;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = MD_W'(m_data_q);
	assign m_tuser   = m_sat_q;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and unit operands.
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		mul_start = 1'b0;
		div_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_num   = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (s_tuser == OP_FILTER)) begin
					state_d = coef_ok_q ? ST_BT : ST_XQ;
				end
			end
			ST_XQ: begin
				mul_a     = MA_W'(bandwidth_q);
				mul_b     = MB_W'(period_q);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_XSQ;
			end
			ST_XSQ: begin
				mul_a     = MA_W'(xq_q);
				mul_b     = MB_W'(xq_q);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_T3;
			end
			ST_T3: begin
				mul_a     = MA_W'(xsq_q);
				mul_b     = MB_W'(sharpness_q);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_DCHK;
			end
			ST_DCHK: begin
				state_d = (den_q == '0) ? ST_WW : ST_DIV1;
			end
			ST_DIV1: begin
				div_num   = t1;
				div_start = !issued_q;
				if (div_done) state_d = ST_DIV2;
			end
			ST_DIV2: begin
				div_num   = t2;
				div_start = !issued_q;
				if (div_done) state_d = ST_DIV3;
			end
			ST_DIV3: begin
				div_num   = ACC_W'(t3_q);
				div_start = !issued_q;
				if (div_done) state_d = ST_WW;
			end
			ST_WW: begin
				mul_a     = MA_W'(bandwidth_q);
				mul_b     = MB_W'(bandwidth_q);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_BW;
			end
			ST_BW: begin
				mul_a     = MA_W'(ww_q);
				mul_b     = MB_W'(c1_q);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_KC;
			end
			ST_KC: begin
				state_d = ST_BT;
			end
			ST_BT: begin
				mul_a     = MA_W'(coef_b_q);
				mul_b     = MB_W'(du_mag);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_K1;
			end
			ST_K1: begin
				mul_a     = MA_W'(k1_mag);
				mul_b     = MB_W'(y0_mag);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_K2;
			end
			ST_K2: begin
				mul_a     = MA_W'(k2_mag);
				mul_b     = MB_W'(y1_mag);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_K3;
			end
			ST_K3: begin
				mul_a     = MA_W'(k3_mag);
				mul_b     = MB_W'(y2_mag);
				mul_start = !issued_q;
				if (mul_done) state_d = ST_RND;
			end
			ST_RND: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control flags, registers, history and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issued_q    <= 1'b0;
			coef_ok_q   <= 1'b0;
			bandwidth_q <= RST_BANDWIDTH;
			sharpness_q <= RST_SHARPNESS;
			period_q    <= RST_SAMPLE_PERIOD;
			hu0_q       <= '0;
			hu1_q       <= '0;
			hu2_q       <= '0;
			hy0_q       <= '0;
			hy1_q       <= '0;
			hy2_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (mul_start || div_start) begin
				issued_q <= 1'b1;
			end else if (mul_done || div_done) begin
				issued_q <= 1'b0;
			end

			if (cfg_acc) begin
				coef_ok_q <= 1'b0;
				case (cfg_index)
					CFG_BANDWIDTH:     bandwidth_q <= cfg_data[BW_W-1:0];
					CFG_SHARPNESS:     sharpness_q <= cfg_data[SH_W-1:0];
					CFG_SAMPLE_PERIOD: period_q    <= cfg_data[SP_W-1:0];
					default:           ;
				endcase
			end else if (state_q == ST_KC) begin
				coef_ok_q <= 1'b1;
			end

			if (in_acc && (s_tuser == OP_CLEAR)) begin
				hu0_q <= '0;
				hu1_q <= '0;
				hu2_q <= '0;
				hy0_q <= '0;
				hy1_q <= '0;
				hy2_q <= '0;
			end else if ((state_q == ST_OUT) && out_free) begin
				hu2_q <= hu1_q;
				hu1_q <= hu0_q;
				hu0_q <= u_q;
				hy2_q <= hy1_q;
				hy1_q <= hy0_q;
				hy0_q <= $signed(y_next);
			end

			if ((state_q == ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Coefficients, accumulator and result payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			u_q <= $signed(s_tdata[SAMPLE_WIDTH-1:0]);
		end
		case (state_q)
			ST_XQ: begin
				if (mul_done) xq_q <= prod[XQ_SHIFT +: XQ_W];
			end
			ST_XSQ: begin
				if (mul_done) begin
					xsq_q <= prod[XSQ_W-1:0];
					den_q <= t1 + t2;
				end
			end
			ST_T3: begin
				if (mul_done) begin
					t3_q  <= prod[T3_W-1:0];
					den_q <= den_q + prod;
				end
			end
			ST_DCHK: begin
				// A zero denominator leaves every coefficient at zero.
				c1_q <= '0;
				c2_q <= '0;
				c3_q <= '0;
			end
			ST_DIV1: begin
				if (div_done) c1_q <= quot;
			end
			ST_DIV2: begin
				if (div_done) c2_q <= quot;
			end
			ST_DIV3: begin
				if (div_done) c3_q <= quot;
			end
			ST_WW: begin
				if (mul_done) ww_q <= prod[WW_W-1:0];
			end
			ST_BW: begin
				if (mul_done) coef_b_q <= prod[B_SHIFT +: B_W];
			end
			ST_KC: begin
				k3_q <= K_W'(c2_q) - K_W'(c1_q) - K_W'(c3_q);
				k2_q <= K_W'(c1_q) + K_W'(c2_q) - K_W'(c3_q) - (K_W'(c3_q) << 1);
				k1_q <= K_W'(c1_q) - K_W'(c2_q) - K_W'(c3_q) - (K_W'(c3_q) << 1);
			end
			ST_BT: begin
				if (mul_done) begin
					acc_q <= du[DU_W-1] ? (ACC_W'(0) - (prod << BT_SHIFT))
					                    : (prod << BT_SHIFT);
				end
			end
			ST_K1: begin
				if (mul_done) acc_q <= (k1_q[K_W-1] ^ hy0_q[OW-1]) ? acc_q - prod : acc_q + prod;
			end
			ST_K2: begin
				if (mul_done) acc_q <= (k2_q[K_W-1] ^ hy1_q[OW-1]) ? acc_q - prod : acc_q + prod;
			end
			ST_K3: begin
				if (mul_done) acc_q <= (k3_q[K_W-1] ^ hy2_q[OW-1]) ? acc_q - prod : acc_q + prod;
			end
			ST_RND: begin
				acc_q <= acc_q + (ACC_W'(1) << (F - 1));
			end
			ST_OUT: begin
				if (out_free) begin
					m_data_q <= y_next;
					m_sat_q  <= !fits;
				end
			end
			default: ;
		endcase
	end

endmodule

/* tb/sv/tb_second_order_pseudo_differentiator.sv */
// Self-checking testbench for the second-order pseudo-differentiator stream block.
module tb_second_order_pseudo_differentiator import sopd_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint FILT_MAX = (64'sd1 <<< 47) - 1;
	localparam longint FILT_MIN = -(64'sd1 <<< 47);

	// Register index that lies beyond the register list.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// Scoreboard: a fixed-point copy of the filter and the queue of pending outputs.
	class sopd_scoreboard;
		typedef struct {
			logic [47:0] filtered;
			bit          saturated;
		} filt_out_t;

		filt_out_t   pending_q[$];
		logic [23:0] bw_reg;
		logic [15:0] sh_reg;
		logic [31:0] sp_reg;
		longint      past_in[3];
		longint      past_out[3];
		int          errors;
		int          n_filter;
		int          n_clear;
		int          n_sat;

		function new();
			bw_reg = RST_BANDWIDTH;
			sh_reg = RST_SHARPNESS;
			sp_reg = RST_SAMPLE_PERIOD;
			past_in = '{0, 0, 0};
			past_out = '{0, 0, 0};
		endfunction

		function logic signed [127:0] wide(longint v);
			return v;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_BANDWIDTH:     bw_reg = data[BW_W-1:0];
				CFG_SHARPNESS:     sh_reg = data[SH_W-1:0];
				CFG_SAMPLE_PERIOD: sp_reg = data[SP_W-1:0];
				default: ;
			endcase
		endfunction

		// Note one accepted request and work out the output it causes.
		function void note_request(logic op, logic [23:0] smp);
			logic [63:0]              xq;
			logic [191:0]             t1, t2, t3, den;
			logic [63:0]              c1, c2, c3, b;
			logic [127:0]             bwc;
			longint                   k1, k2, k3, u, du, y;
			logic signed [127:0]      acc, bb;
			filt_out_t                e;
			bit                       sat;
			if (op == OP_CLEAR) begin
				past_in = '{0, 0, 0};
				past_out = '{0, 0, 0};
				n_clear++;
				return;
			end
			u = {{40{smp[23]}}, smp};
			xq = (64'(bw_reg) * 64'(sp_reg)) >> 16;
			t1 = 192'(sh_reg) << 50;
			t2 = 192'(xq) << 37;
			t3 = 192'(xq) * 192'(xq) * 192'(sh_reg);
			den = t1 + t2 + t3;
			c1 = '0; c2 = '0; c3 = '0; b = '0;
			if (den != 0) begin
				c1 = 64'((t1 << 30) / den);
				c2 = 64'((t2 << 30) / den);
				c3 = 64'((t3 << 30) / den);
				bwc = 128'(64'(bw_reg) * 64'(bw_reg)) * 128'(c1);
				b = 64'(bwc >> 24);
			end
			k3 = c2 - c1 - c3;
			k2 = c1 + c2 - 3 * c3;
			k1 = c1 - c2 - 3 * c3;
			du = past_in[2] - past_in[1] - past_in[0] + u;
			bb = 128'(b);
			acc = (bb * wide(du)) <<< 8;
			acc = acc + wide(k1) * wide(past_out[0]) + wide(k2) * wide(past_out[1])
				+ wide(k3) * wide(past_out[2]);
			// Round half up, then drop the fraction bits.
			acc = (acc + (128'sd1 <<< 29)) >>> 30;
			sat = 1'b1;
			if (acc > wide(FILT_MAX)) y = FILT_MAX;
			else if (acc < wide(FILT_MIN)) y = FILT_MIN;
			else begin
				y = 64'(acc);
				sat = 1'b0;
			end
			past_in[2] = past_in[1];
			past_in[1] = past_in[0];
			past_in[0] = u;
			past_out[2] = past_out[1];
			past_out[1] = past_out[0];
			past_out[0] = y;
			e.filtered = y[47:0];
			e.saturated = sat;
			pending_q.push_back(e);
			n_filter++;
			if (sat) n_sat++;
		endfunction

		// Compare one output against the oldest pending expectation.
		function void check_result(logic [47:0] filtered, logic saturated);
			filt_out_t e;
			if (pending_q.size() == 0) begin
				$error("unexpected output filtered=%h saturated=%b", filtered, saturated);
				errors++;
				return;
			end
			e = pending_q.pop_front();
			if (filtered !== e.filtered) begin
				$error("filtered: expected %h, got %h", e.filtered, filtered);
				errors++;
			end
			if (saturated !== e.saturated) begin
				$error("saturated: expected %b, got %b", e.saturated, saturated);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [23:0]           s_tdata;    // sample
	logic                  s_tuser;    // operation
	logic                  m_tvalid;
	logic                  m_tready;
	logic [47:0]           m_tdata;    // filtered
	logic                  m_tuser;    // saturated
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sopd_scoreboard sb;
	int             send_idle;
	int             recv_idle;
	int             hold_cycles;
	int             n_cfg;

	second_order_pseudo_differentiator dut (.*);

	always #4 clk = ~clk;

	// Receiver: random stalls, plus long hold-offs on request.
	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Output monitor.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
	end

	// Send one request; called and returning at a falling edge.
	task automatic send_request(logic op, logic [23:0] smp);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= smp;
		do @(posedge clk); while (!s_tready);
		sb.note_request(op, smp);
		@(negedge clk);
	endtask

	// Wait until every pending output has come, then let the block settle.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, data);
		n_cfg++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all(logic [31:0] bw, logic [31:0] sh, logic [31:0] sp);
		write_reg(CFG_BANDWIDTH, bw);
		write_reg(CFG_SHARPNESS, sh);
		write_reg(CFG_SAMPLE_PERIOD, sp);
	endtask

	function automatic logic [23:0] rand_sample();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($urandom_range(200)) - 24'd100;
			2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($urandom_range(20000)) - 24'd10000;
		endcase
	endfunction

	function automatic logic [31:0] rand_reg(int width);
		case ($urandom_range(4))
			0: return 32'd1;
			1: return 32'((33'd1 << width) - 1);
			default: return 32'($urandom) & 32'((33'd1 << width) - 1);
		endcase
	endfunction

	initial begin
		#5ms;
		$display("tb: failure");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = OP_FILTER;
		cfg_valid = 1'b0;
		cfg_index = CFG_BANDWIDTH;
		cfg_data = '0;
		send_idle = 0;
		recv_idle = 0;
		hold_cycles = 0;
		n_cfg = 0;
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: sample extremes with the reset registers, and a clear.
		send_request(OP_FILTER, 24'd0);
		send_request(OP_FILTER, 24'h7FFFFF);
		send_request(OP_FILTER, 24'h800000);
		send_request(OP_FILTER, 24'h7FFFFF);
		send_request(OP_FILTER, 24'hFFFFFF);
		send_request(OP_FILTER, 24'd1);
		send_request(OP_CLEAR, 24'h5A5A5A);
		send_request(OP_FILTER, 24'h800000);
		drain();
		// Largest bandwidth and period with a sharp peak: drives saturation.
		write_all(32'hFFFFFF, 32'd1, 32'hFFFFFFFF);
		repeat (4) send_request(OP_FILTER, 24'h7FFFFF);
		send_request(OP_FILTER, 24'h800000);
		drain();
		// Smallest bandwidth and period, largest sharpness.
		write_all(32'd1, 32'hFFFF, 32'd1);
		repeat (3) send_request(OP_FILTER, 24'h7FFFFF);
		drain();
		// Zero denominator: sharpness zero and a product too small to reach x.
		write_all(32'd1, 32'd0, 32'd1);
		send_request(OP_FILTER, 24'h7FFFFF);
		send_request(OP_FILTER, 24'h800000);
		drain();
		// An index beyond the register list is ignored.
		write_reg(CFG_UNUSED, 32'hFFFFFFFF);
		send_request(OP_CLEAR, 24'd0);
		send_request(OP_FILTER, 24'h123456);
		drain();

		// Random phases, each with its own register setting and idle pattern.
		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 26 : (ph == 1) ? 72 : 0;
			recv_idle = (ph == 0) ? 72 : (ph == 1) ? 26 : 0;
			if (ph == 2) write_all(32'(RST_BANDWIDTH), 32'(RST_SHARPNESS),
				32'(RST_SAMPLE_PERIOD));
			else write_all(rand_reg(BW_W), rand_reg(SH_W), rand_reg(SP_W));
			if (ph == 0) hold_cycles = 500;
			for (int i = 0; i < 145; i++) begin
				if (i == 70) begin
					drain();
					write_all(rand_reg(BW_W), rand_reg(SH_W), rand_reg(SP_W));
				end
				if ($urandom_range(99) < 4) send_request(OP_CLEAR, 24'($urandom));
				else send_request(OP_FILTER, rand_sample());
			end
			drain();
		end

		if (sb.pending_q.size() != 0) begin
			$error("%0d expected outputs never arrived", sb.pending_q.size());
			sb.errors++;
		end
		$display("covered %0d filter and %0d clear requests, %0d saturated outputs,",
			sb.n_filter, sb.n_clear, sb.n_sat);
		$display("%0d register writes across extreme and random settings", n_cfg);
		if (sb.errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
